@@ src/imdu_pkg.sv @@
package imdu_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned ACT_W = 3;
	// Divider retires this many quotient bits per stage
	localparam int unsigned BITS_PER_STAGE = 2;
	localparam int unsigned DIV_STAGES = XLEN / BITS_PER_STAGE;

	typedef enum logic [ACT_W-1:0] {
		ACT_MUL  = 3'd0,
		ACT_DIV  = 3'd1,
		ACT_REM  = 3'd2,
		ACT_DIVU = 3'd3,
		ACT_REMU = 3'd4
	} action_t;

	// Per-item control carried alongside the divider data
	typedef struct packed {
		logic       want_rem;
		logic       neg_q;
		logic       neg_r;
		logic       div_zero;
		logic       is_mul;
		logic       is_bad;
	} div_ctl_t;

endpackage

@@ src/int_mul_div_unit.sv @@
// Channel  | Dir | Payload
// s_axis   | in  | tdata: action[2:0], operand_a[34:3], operand_b[66:35], pad to 72
// m_axis   | out | tdata: result[31:0]
//
// 18 register stages (2 front stages, 16 divider stages at 2 quotient bits each):
// one item per cycle sustained while the output register is not stalled.
// The radix-4 divider pipeline sets the depth. Reset clears only the valid bits.
// The whole pipe freezes while the output register holds an item that is not taken;
// s_axis_tready follows that.
module int_mul_div_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // action, operand_a, operand_b
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // result
);
	import imdu_pkg::*;

	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	logic [ACT_W-1:0] act_in;
	logic [XLEN-1:0]  a_in, b_in;
	assign act_in = s_axis_tdata[2:0];
	assign a_in   = s_axis_tdata[34:3];
	assign b_in   = s_axis_tdata[66:35];

	// Stage 1: register operands and the low half of the product
	logic             vld_s1;
	logic [ACT_W-1:0] act_s1;
	logic [XLEN-1:0]  a_s1, b_s1;
	logic [XLEN-1:0]  prod_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1  <= act_in;
			a_s1    <= a_in;
			b_s1    <= b_in;
			prod_s1 <= a_in * b_in;
		end
	end

	// Stage 2: magnitudes and control
	logic            sgn;
	logic            na, nb;
	div_ctl_t        ctl_c;
	always_comb begin
		sgn = (act_s1 == ACT_DIV) || (act_s1 == ACT_REM);
		na  = sgn && a_s1[XLEN-1];
		nb  = sgn && b_s1[XLEN-1];
		ctl_c.want_rem = (act_s1 == ACT_REM) || (act_s1 == ACT_REMU);
		ctl_c.neg_q    = na ^ nb;
		ctl_c.neg_r    = na;
		ctl_c.div_zero = (b_s1 == '0);
		ctl_c.is_mul   = (act_s1 == ACT_MUL);
		ctl_c.is_bad   = !(ctl_c.is_mul || sgn || act_s1 == ACT_DIVU || act_s1 == ACT_REMU);
	end

	logic            vld_s2;
	div_ctl_t        ctl_s2;
	logic [XLEN-1:0] ma_s2, mb_s2, a_s2, lo_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_c;
			ma_s2  <= na ? (~a_s1 + 1'b1) : a_s1;
			mb_s2  <= nb ? (~b_s1 + 1'b1) : b_s1;
			a_s2   <= a_s1;
			lo_s2  <= prod_s1;
		end
	end

	imdu_div_pipe u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (vld_s2),
		.in_ctl     (ctl_s2),
		.in_mag_a   (ma_s2),
		.in_mag_b   (mb_s2),
		.in_raw_a   (a_s2),
		.in_mul_lo  (lo_s2),
		.out_valid  (m_axis_tvalid),
		.out_result (m_axis_tdata)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked while output empty");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |=> vld_s1 == $past(s_axis_tvalid))
		else $error("stage 1 valid lost");

endmodule

@@ src/imdu_div_pipe.sv @@
module imdu_div_pipe (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  imdu_pkg::div_ctl_t       in_ctl,
	input  logic [imdu_pkg::XLEN-1:0] in_mag_a,
	input  logic [imdu_pkg::XLEN-1:0] in_mag_b,
	input  logic [imdu_pkg::XLEN-1:0] in_raw_a,
	input  logic [imdu_pkg::XLEN-1:0] in_mul_lo,
	output logic                     out_valid,
	output logic [imdu_pkg::XLEN-1:0] out_result
);
	import imdu_pkg::*;

	localparam int unsigned N = DIV_STAGES;

	// Per stage: partial remainder, remaining dividend bits / quotient, divisor
	logic [XLEN-1:0] rem_s  [N+1];
	logic [XLEN-1:0] quo_s  [N+1];
	logic [XLEN-1:0] dvs_s  [N+1];
	logic [XLEN-1:0] raw_s  [N+1];
	div_ctl_t        ctl_s  [N+1];
	logic            vld_s  [N+1];

	assign rem_s[0] = '0;
	assign quo_s[0] = in_mag_a;
	assign dvs_s[0] = in_mag_b;
	assign raw_s[0] = in_ctl.is_mul ? in_mul_lo : in_raw_a;
	assign ctl_s[0] = in_ctl;
	assign vld_s[0] = in_valid;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [XLEN-1:0] r_n;
		logic [XLEN-1:0] q_n;
		logic [XLEN:0]   t;
		logic [XLEN:0]   d;
		always_comb begin
			r_n = rem_s[g];
			q_n = quo_s[g];
			for (int k = 0; k < BITS_PER_STAGE; k++) begin
				t = {r_n, q_n[XLEN-1]};
				d = t - {1'b0, dvs_s[g]};
				q_n = {q_n[XLEN-2:0], ~d[XLEN]};
				r_n = d[XLEN] ? t[XLEN-1:0] : d[XLEN-1:0];
			end
		end
		logic [XLEN-1:0] rem_r, quo_r, dvs_r, raw_r;
		div_ctl_t        ctl_r;
		logic            vld_r;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_r <= 1'b0;
			end else if (adv) begin
				vld_r <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_r <= r_n;
				quo_r <= q_n;
				dvs_r <= dvs_s[g];
				raw_r <= raw_s[g];
				ctl_r <= ctl_s[g];
			end
		end
		assign rem_s[g+1] = rem_r;
		assign quo_s[g+1] = quo_r;
		assign dvs_s[g+1] = dvs_r;
		assign raw_s[g+1] = raw_r;
		assign ctl_s[g+1] = ctl_r;
		assign vld_s[g+1] = vld_r;
	end

	div_ctl_t        c;
	logic [XLEN-1:0] q_fix, r_fix;
	always_comb begin
		c = ctl_s[N];
		q_fix = c.neg_q ? (~quo_s[N] + 1'b1) : quo_s[N];
		r_fix = c.neg_r ? (~rem_s[N] + 1'b1) : rem_s[N];
		if (c.is_bad) begin
			out_result = '0;
		end else if (c.is_mul) begin
			out_result = raw_s[N];
		end else if (c.div_zero) begin
			out_result = c.want_rem ? raw_s[N] : '1;
		end else begin
			out_result = c.want_rem ? r_fix : q_fix;
		end
	end
	assign out_valid = vld_s[N];

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import imdu_pkg::*;

	localparam int unsigned LATENCY = 18;
	localparam int unsigned CYCLE_LIMIT = 400000;

	class result_board;
		logic [31:0] pending[$];
		int unsigned errors;
		int unsigned matched;

		function void note_item(logic [31:0] value);
			pending.push_back(value);
		endfunction

		function void check_result(logic [31:0] got);
			logic [31:0] want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing expected", got));
				return;
			end
			want = pending.pop_front();
			if (got !== want)
				report_mismatch($sformatf("result %h, expected %h", got, want));
			else
				matched++;
		endfunction

		function void report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;

	result_board board;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          hold_off;
	int unsigned sent;
	longint unsigned cycles;

	int_mul_div_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [31:0] negate(logic [31:0] v);
		return ~v + 32'd1;
	endfunction

	function automatic logic [31:0] muldiv_result(logic [2:0] act, logic [31:0] a,
			logic [31:0] b);
		logic [63:0] prod;
		logic [31:0] mag_a, mag_b, quo, rem;
		prod = {32'd0, a} * {32'd0, b};
		mag_a = a[31] ? negate(a) : a;
		mag_b = b[31] ? negate(b) : b;
		if (b != 0) begin
			quo = mag_a / mag_b;
			rem = mag_a % mag_b;
		end else begin
			quo = '0;
			rem = '0;
		end
		case (act)
			ACT_MUL:  return prod[31:0];
			ACT_DIV:  return (b == 0) ? 32'hFFFF_FFFF : ((a[31] != b[31]) ? negate(quo) : quo);
			ACT_REM:  return (b == 0) ? a : (a[31] ? negate(rem) : rem);
			ACT_DIVU: return (b == 0) ? 32'hFFFF_FFFF : a / b;
			ACT_REMU: return (b == 0) ? a : a % b;
			default:  return '0;
		endcase
	endfunction

	// Offer one item; drop valid while idling, hold the item until taken
	task automatic send_item(logic [2:0] act, logic [31:0] a, logic [31:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, b, a, act};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_item(muldiv_result(act, a, b));
		sent++;
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(15);
			5: return negate($urandom_range(15));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random(int unsigned count);
		logic [2:0]  act;
		logic [31:0] a, b;
		repeat (count) begin
			act = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
			a = pick_operand();
			b = pick_operand();
			if ($urandom_range(29) == 0) begin
				a = 32'h8000_0000;
				b = 32'hFFFF_FFFF;
			end
			send_item(act, a, b);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Receiver: random stalls, or a long hold-off while the sender keeps offering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata);
			m_axis_tready <= !hold_off &&
				(recv_stall_pct == 0 || $urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("int_mul_div_unit regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned hold_cycles;
		board = new();
		hold_off = 1'b0;
		sent = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every operation, extremes, divide by zero, signed overflow
		send_item(ACT_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(ACT_MUL, 32'h8000_0000, 32'h0000_0002);
		send_item(ACT_MUL, 32'h0000_0000, 32'h1234_5678);
		send_item(ACT_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item(ACT_REM, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item(ACT_DIV, 32'hFFFF_FFF9, 32'h0000_0002);
		send_item(ACT_REM, 32'hFFFF_FFF9, 32'h0000_0002);
		send_item(ACT_DIV, 32'h0000_0007, 32'hFFFF_FFFE);
		send_item(ACT_REM, 32'h0000_0007, 32'hFFFF_FFFE);
		send_item(ACT_DIV, 32'h1234_5678, 32'h0000_0000);
		send_item(ACT_REM, 32'h8765_4321, 32'h0000_0000);
		send_item(ACT_DIVU, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(ACT_REMU, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(ACT_DIVU, 32'hFFFF_FFFF, 32'h0000_0001);
		send_item(ACT_REMU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(ACT_DIVU, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(ACT_REMU, 32'h0000_0003, 32'hFFFF_FFFF);
		send_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(3'd6, 32'h1234_5678, 32'h0000_0000);
		send_item(3'd7, 32'h8000_0000, 32'hFFFF_FFFF);
		drain();

		send_random(100);
		send_idle_pct = 78;
		send_random(80);
		send_idle_pct = 0;
		recv_stall_pct = 78;
		send_random(80);
		send_idle_pct = 22;
		recv_stall_pct = 22;
		send_random(80);
		send_idle_pct = 0;
		recv_stall_pct = 0;

		// back the pipe up: receiver holds off while items keep coming
		fork
			begin
				hold_off = 1'b1;
				hold_cycles = 0;
				while (hold_cycles < 3 * LATENCY) begin
					@(posedge clk);
					hold_cycles++;
				end
				hold_off = 1'b0;
			end
			send_random(60);
		join
		drain();

		$display("covered %0d items (%0d results matched) over all five operations and unused codes,",
			sent, board.matched);
		$display("with divide by zero, signed overflow, idling and backpressure phases");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("int_mul_div_unit regression: pass");
		else
			$display("int_mul_div_unit regression: fail");
		$finish;
	end
endmodule

@@ sim.f @@
src/imdu_pkg.sv
src/imdu_div_pipe.sv
src/int_mul_div_unit.sv
verif/tb.sv
